// ===== rtl/round_robin_multi_fifo_top_assert.svh =====
// Assertion macros for the round-robin FIFO bank
`ifndef ROUND_ROBIN_MULTI_FIFO_TOP_ASSERT_SVH
`define ROUND_ROBIN_MULTI_FIFO_TOP_ASSERT_SVH

// check a property every clock outside reset
`define RRMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition is followed by another on the next clock
`define RRMF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/rrmf_pkg.sv =====
// Shared types and codes for the round-robin FIFO bank
`default_nettype none

package rrmf_pkg;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [31:0] item_value;
		logic [3:0]  consumer_id;
	} item_t;

	typedef struct packed {
		logic        success;
		logic [31:0] data_out;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/rrmf_store.sv =====
// Single-port word store with registered read data for the FIFO bank
`default_nettype none

module rrmf_store #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/round_robin_multi_fifo_top.sv =====
// Round-robin FIFO bank: one producer enqueues in turn, consumers dequeue their own FIFO
//
// The bank takes one item in every clock cycle: busy never rises, and no clearing pass
// runs after reset, since the per-FIFO occupancy counters alone decide which store entries
// are live. An item accepted at one edge has its pointers looked up, its store word written
// or read and its pointers updated at that same edge; its result is on the result port, with
// done high, during the following cycle only, and the store's read register holds the read
// word for it. The receiver cannot hold results off, so it must take the result in
// that cycle. An enqueue goes to the FIFO named by the round-robin pointer, which advances
// on every enqueue, also a refused one. A dequeue of a full-range but nonexistent consumer
// reports empty.
`default_nettype none

module round_robin_multi_fifo_top #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rrmf_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output rrmf_pkg::result_t result
);

	import rrmf_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
	localparam logic [31:0] NQ_W = NUM_QUEUES;

	logic [QW-1:0] next_q;
	logic [DW-1:0] wr_idx_q [NUM_QUEUES];
	logic [DW-1:0] rd_idx_q [NUM_QUEUES];
	logic [CW-1:0] occ_q    [NUM_QUEUES];

	logic          done_q;
	logic          rd_ok_s1;
	logic          success_s1;

	logic          accept;
	logic          is_enq;
	logic [31:0]   cid_w;
	logic          cid_ok;
	logic [QW-1:0] q_sel;
	logic [QW-1:0] next_q_nxt;
	logic [CW-1:0] occ_sel;
	logic [DW-1:0] idx_sel;
	logic [DW-1:0] idx_next;
	logic          enq_ok;
	logic          deq_ok;
	logic [AW-1:0] mem_addr;
	logic [SW-1:0] rdata;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign is_enq = (item.operation == OP_ENQ);
	assign cid_w  = 32'(item.consumer_id);
	assign cid_ok = (cid_w < NQ_W);

	always_comb begin
		q_sel      = is_enq ? next_q : cid_w[QW-1:0];
		occ_sel    = occ_q[q_sel];
		idx_sel    = is_enq ? wr_idx_q[q_sel] : rd_idx_q[q_sel];
		idx_next   = (idx_sel == DW'(QUEUE_DEPTH - 1)) ? '0 : idx_sel + 1'b1;
		next_q_nxt = (next_q == QW'(NUM_QUEUES - 1)) ? '0 : next_q + 1'b1;
		enq_ok     = is_enq && (occ_sel != CW'(QUEUE_DEPTH));
		deq_ok     = !is_enq && cid_ok && (occ_sel != '0);
		mem_addr   = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(idx_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
				occ_q[i]    <= '0;
			end
		end else begin
			done_q <= accept;
			if (accept) begin
				if (is_enq) begin
					next_q <= next_q_nxt;
				end
				if (enq_ok) begin
					wr_idx_q[q_sel] <= idx_next;
					occ_q[q_sel]    <= occ_sel + 1'b1;
				end
				if (deq_ok) begin
					rd_idx_q[q_sel] <= idx_next;
					occ_q[q_sel]    <= occ_sel - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1   <= deq_ok;
			success_s1 <= enq_ok | deq_ok;
		end
	end

	rrmf_store #(
		.DEPTH(NUM_QUEUES * QUEUE_DEPTH),
		.WIDTH(SW)
	) u_store (
		.clk  (clk),
		.we   (accept & enq_ok),
		.re   (accept & deq_ok),
		.addr (mem_addr),
		.wdata(item.item_value[SW-1:0]),
		.rdata(rdata)
	);

	assign done            = done_q;
	assign result.success  = success_s1;
	assign result.data_out = rd_ok_s1 ? 32'(rdata) : 32'd0;

`include "round_robin_multi_fifo_top_assert.svh"

	`RRMF_ASSERT_NEXT(a_done_follows_accept, accept, done, "accepted item gave no result")
	`RRMF_ASSERT_NEXT(a_no_spurious_done, !accept, !done, "result without an accepted item")
	`RRMF_ASSERT(a_fail_zero, !done || result.success || !(|result.data_out), "data on failure")
	`RRMF_ASSERT(a_ptr_range, 32'(next_q) < NQ_W, "round-robin pointer out of range")
	`RRMF_ASSERT(a_occ_bound, 32'(occ_q[next_q]) <= 32'(QUEUE_DEPTH), "occupancy above depth")

endmodule

`default_nettype wire

// ===== test/rrmf_checker.sv =====
// Checker for the round-robin FIFO bank: tracks accepted items, predicts and compares results
module rrmf_checker #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rrmf_pkg::item_t   item,
	input  logic              busy,
	input  logic              done,
	input  rrmf_pkg::result_t result,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rrmf_pkg::*;

	logic [31:0] bank_words [NUM_QUEUES][$];
	int unsigned rr_ptr;
	result_t     results_due[$];

	task automatic flag_error(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
		fail_count++;
	endtask

	function automatic result_t predict_access(input item_t it);
		result_t     r;
		int unsigned q;
		r = '0;
		if (it.operation == OP_ENQ) begin
			q = rr_ptr;
			rr_ptr = (rr_ptr + 1 >= NUM_QUEUES) ? 0 : rr_ptr + 1;
			if (bank_words[q].size() < QUEUE_DEPTH) begin
				bank_words[q] = {bank_words[q], it.item_value};
				r.success = 1'b1;
			end
		end else if (it.consumer_id < NUM_QUEUES) begin
			q = it.consumer_id;
			if (bank_words[q].size() != 0) begin
				r.data_out = bank_words[q].pop_front();
				r.success  = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (results_due.size() == 0) begin
					flag_error("unexpected result", result.data_out, 32'h0);
				end else begin
					want = results_due.pop_front();
					if (result.success !== want.success)
						flag_error("success", {31'h0, result.success}, {31'h0, want.success});
					if (result.data_out !== want.data_out)
						flag_error("data_out", result.data_out, want.data_out);
				end
			end
			if (start && !busy)
				results_due = {results_due, predict_access(item)};
		end
		pending <= results_due.size();
	end
endmodule

// ===== test/tb.sv =====
// Testbench top for the round-robin FIFO bank: stimulus, clock, reset and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrmf_pkg::*;

	localparam int NUM_QUEUES  = 16;
	localparam int QUEUE_DEPTH = 1024;
	localparam int RANDOM_ITEMS = 720;
	localparam int LATE_ITEMS   = 300;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;
	int      fail_count;
	int      pending;
	int      burst_left = 0;

	round_robin_multi_fifo_top #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	rrmf_checker #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAIL round_robin_multi_fifo_top");
		$finish;
	end

	task automatic issue_access(input op_t op, input logic [31:0] value, input logic [3:0] cid);
		int idle;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
			idle = $urandom_range(0, 8);
			if (idle != 0) begin
				start <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item  <= '{operation: op, item_value: value, consumer_id: cid};
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int guard;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_access(OP_DEQ, 32'h0, 4'd0);
		issue_access(OP_DEQ, 32'hFFFF_FFFF, 4'd15);
		for (int i = 0; i < NUM_QUEUES; i++)
			issue_access(OP_ENQ, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF
				: ((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555) ^ i, 4'(15 - i));
		issue_access(OP_ENQ, 32'h8000_0001, 4'd0);
		issue_access(OP_DEQ, 32'h0, 4'd0);
		issue_access(OP_DEQ, 32'h0, 4'd0);
		issue_access(OP_DEQ, 32'h0, 4'd0);
		issue_access(OP_DEQ, 32'h0, 4'd1);
		issue_access(OP_DEQ, 32'h0, 4'd15);
		issue_access(OP_DEQ, 32'h0, 4'd2);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue_access(($urandom_range(0, 99) < 55) ? OP_ENQ : OP_DEQ, pick_word(),
				4'($urandom_range(0, 15)));

		hold_until_drained();

		for (int i = 0; i < NUM_QUEUES * 3; i++)
			issue_access(OP_DEQ, pick_word(), 4'(i % NUM_QUEUES));

		for (int i = 0; i < LATE_ITEMS; i++)
			issue_access(($urandom_range(0, 99) < 55) ? OP_ENQ : OP_DEQ, pick_word(),
				4'($urandom_range(0, 15)));

		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS round_robin_multi_fifo_top");
		else
			$display("FAIL round_robin_multi_fifo_top");
		$finish;
	end
endmodule
